/* sv/fan_pwm_mode_controller_core_macros.svh */
// ----------------------------------------------------------------------------
// fan pwm mode controller assertion macros
// shared property wrappers for the controller checks
// ----------------------------------------------------------------------------
`ifndef FAN_PWM_MODE_CONTROLLER_CORE_MACROS_SVH
`define FAN_PWM_MODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FPMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FPMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fpmc_pkg.sv */
// ----------------------------------------------------------------------------
// fpmc_pkg
// shared types and fixed constants of the fan pwm mode controller
// ----------------------------------------------------------------------------
package fpmc_pkg;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // mode codes
  localparam logic [1:0] MODE_STD    = 2'd0;
  localparam logic [1:0] MODE_SENSOR = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  // key numbers
  localparam logic [1:0] KEY_SENSOR = 2'd1;
  localparam logic [1:0] KEY_AUTO   = 2'd2;

  // command characters
  localparam logic [7:0] CHAR_STOP    = 8'h73;
  localparam logic [7:0] CHAR_FORWARD = 8'h66;
  localparam logic [7:0] CHAR_REVERSE = 8'h72;
  localparam logic [7:0] CHAR_DIGIT_1 = 8'h31;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  // result widths and saturation limits
  localparam int unsigned PERIOD_W  = 18;
  localparam int unsigned COMPARE_W = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 18'h3FFFF;

  // duty divisors and scaling
  localparam logic [2:0] DUTY_CHAR  = 3'd5;
  localparam logic [2:0] DUTY_KEY   = 3'd2;
  localparam int unsigned ADC_SCALE = 100;
  localparam int unsigned SWEEP_DIV = 10;

  // reciprocal multiply for a period divided by five, exact below 2**18
  localparam int unsigned DIV5_SHIFT = 20;
  localparam logic [PERIOD_W-1:0] DIV5_RECIP = 18'd209716;

  // sweep index / 10 as (index >> 1) / 5, exact for a halved index below 2**20
  localparam int unsigned SWEEP_W     = 21;
  localparam int unsigned SWEEP_SHIFT = 22;
  localparam logic [SWEEP_W-2:0] SWEEP_RECIP = 20'd838861;

  localparam logic [PERIOD_W-1:0] SPEED_RESET = 18'd200000;

  // stored speed frequency for digit characters '1' to '9'
  function automatic logic [PERIOD_W-1:0] digit_speed(input logic [7:0] ch);
    logic [7:0] idx;
    idx = ch - CHAR_DIGIT_1;
    case (idx[3:0])
      4'd0:    digit_speed = 18'd200000;
      4'd1:    digit_speed = 18'd100000;
      4'd2:    digit_speed = 18'd50000;
      4'd3:    digit_speed = 18'd20000;
      4'd4:    digit_speed = 18'd10000;
      4'd5:    digit_speed = 18'd500;
      4'd6:    digit_speed = 18'd100;
      4'd7:    digit_speed = 18'd50;
      4'd8:    digit_speed = 18'd30;
      default: digit_speed = SPEED_RESET;
    endcase
  endfunction

endpackage

/* sv/fpmc_div.sv */
// ----------------------------------------------------------------------------
// fpmc_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fpmc_div #(
  parameter int unsigned W = 21
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [W-1:0]           dividend,
  input  logic [W-1:0]           divisor,
  output logic [W-1:0]           quotient,
  output fpmc_pkg::div_status_t  status
);

  localparam int unsigned CNT_W = $clog2(W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  // trial subtraction of the shifted remainder
  assign rem_sh = {rem, quo[W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* sv/fan_pwm_mode_controller_core.sv */
// ----------------------------------------------------------------------------
// fan_pwm_mode_controller_core
// turns command characters and mode keys into pwm timer settings
// ----------------------------------------------------------------------------
// Usage: one request on the in channel (op, rx_char, mode_key, adc_sample)
// gives exactly one result on the out channel, both valid/ready handshakes.
// A request is taken only while the block is idle; in_ready stays low until
// its result has been taken by the receiver.
// Sequence: stop/forward/reverse characters and standard-mode keys give their
// result in the cycle after the request is taken; a zero sensor frequency
// first passes the load state. A reprogramming request makes one pass of the
// shared restoring divider for the period, at the internal word width (21 bits
// at the default parameters); compare follows from the period by a shift or a
// reciprocal multiply, and an auto-mode key first derives the sweep frequency.
// A new request is taken only after the result has been accepted and the block
// is back in idle, so requests are never overlapped.
// Reset: standard mode, speed 200000, sweep index, period and compare zero,
// counter off, both channels on. A stalled receiver holds the result steady
// and the block takes no new request until it is accepted.
// ----------------------------------------------------------------------------
`include "fan_pwm_mode_controller_core_macros.svh"

module fan_pwm_mode_controller_core #(
  parameter int unsigned BASE_FREQ  = 200000,
  parameter int unsigned SWEEP_WRAP = 2000000,
  parameter int unsigned ADC_BITS   = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [7:0]                     rx_char,
  input  logic [1:0]                     mode_key,
  input  logic [ADC_BITS-1:0]            adc_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           timer_written,
  output logic [fpmc_pkg::PERIOD_W-1:0]  period,
  output logic [fpmc_pkg::COMPARE_W-1:0] compare,
  output logic                           counter_on,
  output logic                           ch3_on,
  output logic                           ch4_on,
  output logic [1:0]                     mode,
  output logic                           zero_divisor
);

  // internal word width covers every dividend, divisor and frequency
  localparam int unsigned BASE_W = $clog2(BASE_FREQ + 1);
  localparam int unsigned IDX_W  = $clog2(SWEEP_WRAP);
  localparam int unsigned ADCF_W = $clog2(((2 ** ADC_BITS) - 1) * fpmc_pkg::ADC_SCALE + 1);
  localparam int unsigned W1 = (BASE_W > IDX_W) ? BASE_W : IDX_W;
  localparam int unsigned W2 = (W1 > ADCF_W) ? W1 : ADCF_W;
  localparam int unsigned W  = (W2 > fpmc_pkg::PERIOD_W) ? W2 : fpmc_pkg::PERIOD_W;

  // reciprocal multiply widths
  localparam int unsigned SW_W    = fpmc_pkg::SWEEP_W;
  localparam int unsigned SPROD_W = 2 * SW_W - 2;
  localparam int unsigned SQUO_W  = SPROD_W - fpmc_pkg::SWEEP_SHIFT;
  localparam int unsigned CPROD_W = 2 * fpmc_pkg::PERIOD_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_PER   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                      state;
  logic [1:0]                      mode_state;
  logic [fpmc_pkg::PERIOD_W-1:0]   speed_freq;
  logic [IDX_W-1:0]                sweep_index;
  logic [fpmc_pkg::PERIOD_W-1:0]   period_reg;
  logic [fpmc_pkg::COMPARE_W-1:0]  compare_reg;
  logic                            counter_enable;
  logic                            reverse_enable;
  logic                            forward_enable;
  logic                            wrote_flag;
  logic                            zero_flag;
  logic [W-1:0]                    freq;
  logic [2:0]                      duty;

  logic                            accept;
  logic                            is_digit;
  logic [IDX_W-1:0]                sweep_base;
  logic [IDX_W:0]                  sweep_inc;
  logic [IDX_W-1:0]                sweep_next;
  logic [SW_W-2:0]                 sweep_half;
  logic [SPROD_W-1:0]              sweep_prod;
  logic [SQUO_W-1:0]               sweep_quo;
  logic [CPROD_W-1:0]              cmp_prod;
  logic [fpmc_pkg::COMPARE_W-1:0]  compare_next;
  logic [W-1:0]                    adc_freq;
  logic [fpmc_pkg::PERIOD_W-1:0]   period_sat;

  logic                            div_start;
  logic [W-1:0]                    div_dvd;
  logic [W-1:0]                    div_dsr;
  logic [W-1:0]                    div_quo;
  fpmc_pkg::div_status_t           div_st;

  assign accept = in_valid && in_ready;

  // digit characters only pick a speed in standard mode
  assign is_digit = (mode_state == fpmc_pkg::MODE_STD) &&
                    (rx_char >= fpmc_pkg::CHAR_DIGIT_1) &&
                    (rx_char <= fpmc_pkg::CHAR_DIGIT_9);

  // sweep index step, cleared first when leaving auto mode
  assign sweep_base = (mode_key == fpmc_pkg::KEY_AUTO) ? '0 : sweep_index;
  assign sweep_inc  = {1'b0, sweep_base} + 1'b1;
  assign sweep_next = (sweep_inc == (IDX_W + 1)'(SWEEP_WRAP)) ? '0 : sweep_inc[IDX_W-1:0];

  // sweep index / 10 from the registered index
  assign sweep_half = (SW_W - 1)'(sweep_index >> 1);
  assign sweep_prod = SPROD_W'(sweep_half) * SPROD_W'(fpmc_pkg::SWEEP_RECIP);
  assign sweep_quo  = sweep_prod[SPROD_W-1:fpmc_pkg::SWEEP_SHIFT];

  // compare from the period: divide by five or halve
  assign cmp_prod     = CPROD_W'(period_reg) * CPROD_W'(fpmc_pkg::DIV5_RECIP);
  assign compare_next = (duty == fpmc_pkg::DUTY_CHAR)
                        ? {1'b0, cmp_prod[CPROD_W-1:fpmc_pkg::DIV5_SHIFT]}
                        : period_reg[fpmc_pkg::PERIOD_W-1:1];

  // sensor frequency
  assign adc_freq = W'(adc_sample) * W'(fpmc_pkg::ADC_SCALE);

  // period saturates at the register width
  assign period_sat = (div_quo > W'(fpmc_pkg::PERIOD_MAX)) ? fpmc_pkg::PERIOD_MAX
                                                            : div_quo[fpmc_pkg::PERIOD_W-1:0];

  // period divide starts once a non-zero frequency is loaded
  assign div_start = (state == ST_LOAD) && (freq != '0);
  assign div_dvd   = W'(BASE_FREQ);
  assign div_dsr   = freq;

  fpmc_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quo),
    .status   (div_st)
  );

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode_state     <= fpmc_pkg::MODE_STD;
      speed_freq     <= fpmc_pkg::SPEED_RESET;
      sweep_index    <= '0;
      period_reg     <= '0;
      compare_reg    <= '0;
      counter_enable <= 1'b0;
      reverse_enable <= 1'b1;
      forward_enable <= 1'b1;
      wrote_flag     <= 1'b0;
      zero_flag      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wrote_flag <= 1'b0;
            zero_flag  <= 1'b0;
            state      <= ST_OUT;
            if (!op) begin
              case (rx_char)
                fpmc_pkg::CHAR_STOP: begin
                  counter_enable <= 1'b0;
                  reverse_enable <= 1'b0;
                  forward_enable <= 1'b0;
                end
                fpmc_pkg::CHAR_FORWARD: begin
                  counter_enable <= 1'b1;
                  forward_enable <= 1'b1;
                  reverse_enable <= 1'b0;
                end
                fpmc_pkg::CHAR_REVERSE: begin
                  counter_enable <= 1'b1;
                  reverse_enable <= 1'b1;
                  forward_enable <= 1'b0;
                end
                default: begin
                  if (is_digit) begin
                    speed_freq <= fpmc_pkg::digit_speed(rx_char);
                    freq       <= W'(fpmc_pkg::digit_speed(rx_char));
                  end else begin
                    freq <= W'(speed_freq);
                  end
                  duty  <= fpmc_pkg::DUTY_CHAR;
                  state <= ST_LOAD;
                end
              endcase
            end else begin
              unique case (mode_state)
                fpmc_pkg::MODE_SENSOR: begin
                  if (mode_key == fpmc_pkg::KEY_SENSOR) begin
                    mode_state <= fpmc_pkg::MODE_STD;
                  end
                  freq  <= adc_freq;
                  duty  <= fpmc_pkg::DUTY_KEY;
                  state <= ST_LOAD;
                end
                fpmc_pkg::MODE_AUTO: begin
                  if (mode_key == fpmc_pkg::KEY_AUTO) begin
                    mode_state <= fpmc_pkg::MODE_STD;
                  end
                  sweep_index <= sweep_next;
                  duty        <= fpmc_pkg::DUTY_KEY;
                  state       <= ST_SWEEP;
                end
                default: begin
                  if (mode_key == fpmc_pkg::KEY_SENSOR) begin
                    mode_state <= fpmc_pkg::MODE_SENSOR;
                  end else if (mode_key == fpmc_pkg::KEY_AUTO) begin
                    mode_state <= fpmc_pkg::MODE_AUTO;
                  end
                end
              endcase
            end
          end
        end
        // sweep frequency is index / 10 + 1
        ST_SWEEP: begin
          freq  <= W'(sweep_quo) + 1'b1;
          state <= ST_LOAD;
        end
        // zero frequency keeps the timer registers
        ST_LOAD: begin
          if (freq == '0) begin
            zero_flag <= 1'b1;
            state     <= ST_OUT;
          end else begin
            state <= ST_PER;
          end
        end
        ST_PER: begin
          if (div_st.done) begin
            period_reg <= period_sat;
            state      <= ST_CMP;
          end
        end
        // compare never exceeds its width after dividing by the duty
        ST_CMP: begin
          compare_reg    <= compare_next;
          counter_enable <= 1'b1;
          wrote_flag     <= 1'b1;
          state          <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign in_ready      = (state == ST_IDLE);
  assign out_valid     = (state == ST_OUT);
  assign timer_written = wrote_flag;
  assign period        = period_reg;
  assign compare       = compare_reg;
  assign counter_on    = counter_enable;
  assign ch3_on        = reverse_enable;
  assign ch4_on        = forward_enable;
  assign mode          = mode_state;
  assign zero_divisor  = zero_flag;

  // checks
  `FPMC_ASSERT_NOW(a_ready_excl, out_valid, !in_ready, "ready while result pending")
  `FPMC_ASSERT_NOW(a_flags_excl, out_valid, !(timer_written && zero_divisor), "both flags set")
  `FPMC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
  `FPMC_ASSERT_NOW(a_div_active, state == ST_PER, div_st.busy || div_st.done, "period pass without divider activity")

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fan pwm mode controller core
// ----------------------------------------------------------------------------
// A queue of requests is filled up front with a short directed part and
// then random traffic. The random traffic is mostly sensor and auto runs with
// random content, plus loose single requests. A clocked driver offers them on
// the in channel. Each accepted request is run through a local model of the
// controller, and the expected setting is queued. A clocked monitor compares
// every result on the out channel, field by field, with the oldest queued
// setting. Idling on both sides goes through several phases. One long
// receiver hold-off stalls the input. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int ADC_W = 12;
  localparam int unsigned FREQ_BASE = 200000;
  localparam int unsigned SWEEP_LEN = 2000000;
  localparam int unsigned PERIOD_LIMIT = 262143;
  localparam int unsigned COMPARE_LIMIT = 131071;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASE_LEN = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 1000;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_KEY  = 1'b1;
  localparam logic [1:0] KEY_NONE  = 2'd0;
  localparam logic [1:0] KEY_SPARE = 2'd3;

  localparam logic [1:0] PH_NONE     = 2'd0;
  localparam logic [1:0] PH_SENDER   = 2'd1;
  localparam logic [1:0] PH_RECEIVER = 2'd2;
  localparam logic [1:0] PH_BOTH     = 2'd3;

  // stored speed for '1' to '9'
  localparam int unsigned SPEED_TABLE [9] = '{200000, 100000, 50000, 20000, 10000,
                                              500, 100, 50, 30};

  typedef struct packed {
    logic             op;
    logic [7:0]       rx_char;
    logic [1:0]       mode_key;
    logic [ADC_W-1:0] adc_sample;
  } fan_cmd_t;

  typedef struct packed {
    logic                           timer_written;
    logic [fpmc_pkg::PERIOD_W-1:0]  period;
    logic [fpmc_pkg::COMPARE_W-1:0] compare;
    logic                           counter_on;
    logic                           ch3_on;
    logic                           ch4_on;
    logic [1:0]                     mode;
    logic                           zero_divisor;
  } fan_setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [7:0] rx_char = '0;
  logic [1:0] mode_key = '0;
  logic [ADC_W-1:0] adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic timer_written;
  logic [fpmc_pkg::PERIOD_W-1:0] period;
  logic [fpmc_pkg::COMPARE_W-1:0] compare;
  logic counter_on;
  logic ch3_on;
  logic ch4_on;
  logic [1:0] mode;
  logic zero_divisor;

  fan_cmd_t cmd_backlog[$];
  fan_setting_t setting_forecast[$];
  fan_setting_t want;

  int errors = 0;
  int cmds_taken = 0;
  int settings_seen = 0;
  int reloads = 0;
  int zero_hits = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [1:0] gen_mode = fpmc_pkg::MODE_STD;

  // local copy of the controller state
  logic [1:0] m_mode = fpmc_pkg::MODE_STD;
  int unsigned m_speed = fpmc_pkg::SPEED_RESET;
  int unsigned m_sweep = 0;
  int unsigned m_sweep_peak = 0;
  int unsigned m_period = 0;
  int unsigned m_compare = 0;
  logic m_count = 1'b0;
  logic m_rev = 1'b1;
  logic m_fwd = 1'b1;

  wire [1:0] idle_phase = 2'((cmds_taken / PHASE_LEN) % 4);

  fan_pwm_mode_controller_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .rx_char(rx_char),
    .mode_key(mode_key),
    .adc_sample(adc_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .timer_written(timer_written),
    .period(period),
    .compare(compare),
    .counter_on(counter_on),
    .ch3_on(ch3_on),
    .ch4_on(ch4_on),
    .mode(mode),
    .zero_divisor(zero_divisor)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected setting after one request, advancing the local state
  function automatic fan_setting_t forecast_setting(input fan_cmd_t c);
    fan_setting_t s;
    int unsigned freq;
    int unsigned p;
    int unsigned q;
    int unsigned duty;
    bit reload;
    s = '0;
    freq = 0;
    duty = fpmc_pkg::DUTY_CHAR;
    reload = 1'b0;
    if (c.op == OP_CHAR) begin
      case (c.rx_char)
        fpmc_pkg::CHAR_STOP: begin
          m_count = 1'b0;
          m_rev = 1'b0;
          m_fwd = 1'b0;
        end
        fpmc_pkg::CHAR_FORWARD: begin
          m_count = 1'b1;
          m_fwd = 1'b1;
          m_rev = 1'b0;
        end
        fpmc_pkg::CHAR_REVERSE: begin
          m_count = 1'b1;
          m_rev = 1'b1;
          m_fwd = 1'b0;
        end
        default: begin
          // digits only pick a new speed in standard mode
          if (m_mode == fpmc_pkg::MODE_STD && c.rx_char >= fpmc_pkg::CHAR_DIGIT_1 &&
              c.rx_char <= fpmc_pkg::CHAR_DIGIT_9)
            m_speed = SPEED_TABLE[c.rx_char - fpmc_pkg::CHAR_DIGIT_1];
          freq = m_speed;
          reload = 1'b1;
        end
      endcase
    end else begin
      case (m_mode)
        fpmc_pkg::MODE_SENSOR: begin
          if (c.mode_key == fpmc_pkg::KEY_SENSOR) m_mode = fpmc_pkg::MODE_STD;
          freq = c.adc_sample * fpmc_pkg::ADC_SCALE;
          duty = fpmc_pkg::DUTY_KEY;
          reload = 1'b1;
        end
        fpmc_pkg::MODE_AUTO: begin
          if (c.mode_key == fpmc_pkg::KEY_AUTO) begin
            m_mode = fpmc_pkg::MODE_STD;
            m_sweep = 0;
          end
          m_sweep = (m_sweep + 1) % SWEEP_LEN;
          if (m_sweep > m_sweep_peak) m_sweep_peak = m_sweep;
          freq = m_sweep / fpmc_pkg::SWEEP_DIV + 1;
          duty = fpmc_pkg::DUTY_KEY;
          reload = 1'b1;
        end
        default: begin
          if (c.mode_key == fpmc_pkg::KEY_SENSOR) m_mode = fpmc_pkg::MODE_SENSOR;
          else if (c.mode_key == fpmc_pkg::KEY_AUTO) m_mode = fpmc_pkg::MODE_AUTO;
        end
      endcase
    end
    // timer reload, kept as is on a zero frequency
    if (reload) begin
      if (freq == 0) begin
        s.zero_divisor = 1'b1;
      end else begin
        p = FREQ_BASE / freq;
        if (p > PERIOD_LIMIT) p = PERIOD_LIMIT;
        q = p / duty;
        if (q > COMPARE_LIMIT) q = COMPARE_LIMIT;
        m_period = p;
        m_compare = q;
        m_count = 1'b1;
        s.timer_written = 1'b1;
      end
    end
    s.period = m_period[fpmc_pkg::PERIOD_W-1:0];
    s.compare = m_compare[fpmc_pkg::COMPARE_W-1:0];
    s.counter_on = m_count;
    s.ch3_on = m_rev;
    s.ch4_on = m_fwd;
    s.mode = m_mode;
    return s;
  endfunction

  function automatic fan_cmd_t make_char(input logic [7:0] ch);
    fan_cmd_t c;
    c = '0;
    c.op = OP_CHAR;
    c.rx_char = ch;
    c.mode_key = 2'($urandom_range(3));
    c.adc_sample = ADC_W'($urandom);
    return c;
  endfunction

  function automatic fan_cmd_t make_key(input logic [1:0] key, input logic [ADC_W-1:0] adc);
    fan_cmd_t c;
    c.op = OP_KEY;
    c.rx_char = 8'($urandom);
    c.mode_key = key;
    c.adc_sample = adc;
    return c;
  endfunction

  // sensor reading with the zero and full-scale ends weighted up
  function automatic logic [ADC_W-1:0] rand_adc();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick < 2) return '0;
    if (pick == 2) return '1;
    if (pick == 3) return ADC_W'($urandom_range(20));
    return ADC_W'($urandom);
  endfunction

  function automatic fan_cmd_t rand_cmd();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(2))
        0: return make_char(fpmc_pkg::CHAR_STOP);
        1: return make_char(fpmc_pkg::CHAR_FORWARD);
        default: return make_char(fpmc_pkg::CHAR_REVERSE);
      endcase
    end
    if (pick < 35) return make_char(8'(fpmc_pkg::CHAR_DIGIT_1 + $urandom_range(8)));
    if (pick < 60) return make_char(8'($urandom));
    return make_key(2'($urandom_range(3)), rand_adc());
  endfunction

  // queue a request and follow the mode it leaves behind
  task automatic add_cmd(input fan_cmd_t c);
    cmd_backlog.push_back(c);
    if (c.op == OP_KEY) begin
      case (gen_mode)
        fpmc_pkg::MODE_SENSOR:
          if (c.mode_key == fpmc_pkg::KEY_SENSOR) gen_mode = fpmc_pkg::MODE_STD;
        fpmc_pkg::MODE_AUTO:
          if (c.mode_key == fpmc_pkg::KEY_AUTO) gen_mode = fpmc_pkg::MODE_STD;
        default: begin
          if (c.mode_key == fpmc_pkg::KEY_SENSOR) gen_mode = fpmc_pkg::MODE_SENSOR;
          else if (c.mode_key == fpmc_pkg::KEY_AUTO) gen_mode = fpmc_pkg::MODE_AUTO;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $time, settings_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_v));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        setting_forecast.push_back(forecast_setting({op, rx_char, mode_key, adc_sample}));
        cmds_taken <= cmds_taken + 1;
      end
      if (cmd_backlog.size() != 0 &&
          !((idle_phase == PH_SENDER && $urandom_range(99) < 47) ||
            (idle_phase == PH_BOTH && $urandom_range(99) < 23))) begin
        {op, rx_char, mode_key, adc_sample} <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off, started once HOLD_OFF_AT requests are taken
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && cmds_taken >= HOLD_OFF_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (setting_forecast.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = setting_forecast.pop_front();
          check_field("timer_written", timer_written, want.timer_written);
          check_field("period", period, want.period);
          check_field("compare", compare, want.compare);
          check_field("counter_on", counter_on, want.counter_on);
          check_field("ch3_on", ch3_on, want.ch3_on);
          check_field("ch4_on", ch4_on, want.ch4_on);
          check_field("mode", mode, want.mode);
          check_field("zero_divisor", zero_divisor, want.zero_divisor);
          if (want.timer_written) reloads++;
          if (want.zero_divisor) zero_hits++;
        end
        settings_seen++;
      end
      if (hold_left > 0 || (!hold_done && cmds_taken >= HOLD_OFF_AT)) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !((idle_phase == PH_RECEIVER && $urandom_range(99) < 47) ||
                       (idle_phase == PH_BOTH && $urandom_range(99) < 23));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("fan_pwm_mode_controller_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int run;
    int unsigned pick;
    fan_cmd_t c;

    // directed: channel commands, reload extremes and every digit
    add_cmd(make_char(fpmc_pkg::CHAR_STOP));
    add_cmd(make_char(fpmc_pkg::CHAR_FORWARD));
    add_cmd(make_char(fpmc_pkg::CHAR_REVERSE));
    add_cmd(make_char(8'h00));
    for (int d = 0; d < 9; d++) add_cmd(make_char(8'(fpmc_pkg::CHAR_DIGIT_1 + d)));
    add_cmd(make_char(8'hFF));
    // keys in standard mode that change nothing
    add_cmd(make_key(KEY_NONE, '1));
    add_cmd(make_key(KEY_SPARE, '0));
    // sensor mode: zero frequency, full scale, digit ignored, leave
    add_cmd(make_key(fpmc_pkg::KEY_SENSOR, '0));
    add_cmd(make_key(KEY_NONE, '0));
    add_cmd(make_key(KEY_SPARE, '1));
    add_cmd(make_char(8'(fpmc_pkg::CHAR_DIGIT_1 + 6)));
    add_cmd(make_key(fpmc_pkg::KEY_SENSOR, ADC_W'(1)));
    // auto mode: one sweep step, then leave
    add_cmd(make_key(fpmc_pkg::KEY_AUTO, '0));
    add_cmd(make_key(KEY_NONE, '1));
    add_cmd(make_key(fpmc_pkg::KEY_AUTO, '0));
    add_cmd(make_key(KEY_SPARE, '1));

    // random: sensor and auto runs with random content, and loose requests
    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if (gen_mode == fpmc_pkg::MODE_SENSOR)
          add_cmd(make_key(fpmc_pkg::KEY_SENSOR, rand_adc()));
        if (gen_mode == fpmc_pkg::MODE_STD)
          add_cmd(make_key(fpmc_pkg::KEY_AUTO, rand_adc()));
        run = $urandom_range(60, 10);
        repeat (run) begin
          if ($urandom_range(9) < 2) c = rand_cmd();
          else c = make_key($urandom_range(1) ? KEY_NONE : KEY_SPARE, rand_adc());
          if (c.op == OP_KEY && c.mode_key == fpmc_pkg::KEY_AUTO)
            c.mode_key = fpmc_pkg::KEY_SENSOR;
          add_cmd(c);
        end
        if (gen_mode == fpmc_pkg::MODE_AUTO)
          add_cmd(make_key(fpmc_pkg::KEY_AUTO, rand_adc()));
      end else if (pick < 45) begin
        if (gen_mode == fpmc_pkg::MODE_AUTO)
          add_cmd(make_key(fpmc_pkg::KEY_AUTO, rand_adc()));
        if (gen_mode == fpmc_pkg::MODE_STD)
          add_cmd(make_key(fpmc_pkg::KEY_SENSOR, rand_adc()));
        run = $urandom_range(30, 5);
        repeat (run) begin
          if ($urandom_range(9) < 2) c = rand_cmd();
          else c = make_key(KEY_NONE, rand_adc());
          if (c.op == OP_KEY && c.mode_key != fpmc_pkg::KEY_SENSOR && $urandom_range(1))
            c.mode_key = $urandom_range(1) ? fpmc_pkg::KEY_AUTO : KEY_SPARE;
          if (c.op == OP_KEY && c.mode_key == fpmc_pkg::KEY_SENSOR) c.mode_key = KEY_NONE;
          add_cmd(c);
        end
        if (gen_mode == fpmc_pkg::MODE_SENSOR)
          add_cmd(make_key(fpmc_pkg::KEY_SENSOR, rand_adc()));
      end else begin
        add_cmd(rand_cmd());
      end
    end

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain: everything offered, accepted and answered
    while (cmd_backlog.size() != 0 || in_valid || setting_forecast.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (setting_forecast.size() != 0)
      report_mismatch($sformatf("%0d settings never arrived", setting_forecast.size()));

    $display("covered %0d requests and %0d results: %0d timer reloads, %0d zero frequencies",
             cmds_taken, settings_seen, reloads, zero_hits);
    $display("idle phases on both sides, one %0d-cycle receiver hold-off, sweep index up to %0d",
             HOLD_OFF_CYCLES, m_sweep_peak);
    if (errors == 0) begin
      $display("fan_pwm_mode_controller_core regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("fan_pwm_mode_controller_core regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/fpmc_pkg.sv
sv/fpmc_div.sv
sv/fan_pwm_mode_controller_core.sv
verif/tb_top.sv
